FILE: hdl/scba_pkg.sv
// ----------------------------------------------------------------------------
// scba_pkg - shared types and constants of the size class block allocator
// Pool geometry, size class selection, status codes and the result record.
// ----------------------------------------------------------------------------
package scba_pkg;

	localparam int POOL_BYTES      = 32768;
	localparam int NUM_CLASSES     = 9;
	localparam int MAX_BLOCK_BYTES = 4096;
	localparam int HEADER_BYTES    = 8;
	localparam int GRAN_BYTES      = 16;

	localparam int NGRAN   = POOL_BYTES / GRAN_BYTES;
	localparam int GRAN_W  = $clog2(NGRAN);
	localparam int GRAN_SH = $clog2(GRAN_BYTES);
	localparam int CARVE_W = GRAN_W + 1;
	localparam int ADDR_W  = 15;
	localparam int SIZE_W  = 12;
	localparam int NEED_W  = SIZE_W + 1;
	localparam int CLASS_W = 4;
	localparam int TAG_W   = CLASS_W;
	localparam int STAT_W  = 3;

	localparam int IN_DATA_W  = ((SIZE_W + ADDR_W + 7) / 8) * 8;
	localparam int OUT_RES_W  = ADDR_W + STAT_W + CLASS_W;
	localparam int OUT_DATA_W = ((OUT_RES_W + 7) / 8) * 8;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_type_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_TOO_LARGE = 3'd1,
		STAT_OOM       = 3'd2,
		STAT_NULL_FREE = 3'd3,
		STAT_BAD_FREE  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [GRAN_W-1:0] idx;
	} head_t;

	// addr sits in the low bits, as on the output stream
	typedef struct packed {
		logic [CLASS_W-1:0] size_class;
		status_t            status;
		logic [ADDR_W-1:0]  addr;
	} result_t;

	// Smallest class whose block holds need bytes; top bit flags a hit.
	function automatic logic [CLASS_W:0] pick_class(input logic [NEED_W-1:0] need);
		logic [CLASS_W:0] sel;
		int               csize;
		sel = '0;
		for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
			csize = GRAN_BYTES << k;
			if (csize <= MAX_BLOCK_BYTES && int'(need) <= csize) begin
				sel = {1'b1, CLASS_W'(k)};
			end
		end
		return sel;
	endfunction

endpackage

FILE: hdl/scba_ram.sv
// ----------------------------------------------------------------------------
// scba_ram - simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module scba_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/scba_ctrl.sv
// ----------------------------------------------------------------------------
// scba_ctrl - request sequencer of the size class block allocator
// Holds the list heads and carve pointer, drives the tag and link memories,
// clears the tag memory after reset and resolves each request.
// ----------------------------------------------------------------------------
module scba_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  scba_pkg::req_type_t         in_type,
	input  logic [scba_pkg::SIZE_W-1:0] in_size,
	input  logic [scba_pkg::ADDR_W-1:0] in_faddr,
	input  logic                        out_free,
	output logic                        res_valid,
	output scba_pkg::result_t           res,
	output logic                        tag_we,
	output logic [scba_pkg::GRAN_W-1:0] tag_waddr,
	output logic [scba_pkg::TAG_W-1:0]  tag_wdata,
	output logic [scba_pkg::GRAN_W-1:0] tag_raddr,
	input  logic [scba_pkg::TAG_W-1:0]  tag_rdata,
	output logic                        link_we,
	output logic [scba_pkg::GRAN_W-1:0] link_waddr,
	output logic [scba_pkg::GRAN_W-1:0] link_wdata,
	output logic [scba_pkg::GRAN_W-1:0] link_raddr,
	input  logic [scba_pkg::GRAN_W-1:0] link_rdata
);
	import scba_pkg::*;

	state_t             state_q, state_d;
	logic [GRAN_W-1:0]  clr_q;
	head_t              heads_q [NUM_CLASSES];
	logic [CARVE_W-1:0] carve_q;

	req_type_t          type_q;
	logic               cls_ok_q;
	logic [CLASS_W-1:0] cls_q;
	head_t              head_q;
	logic [ADDR_W-1:0]  faddr_q;

	logic [CLASS_W:0]   pick_in;
	logic               accept;
	logic               clearing;
	logic               exec;

	logic               x_tag_we;
	logic [GRAN_W-1:0]  x_tag_waddr;
	logic [TAG_W-1:0]   x_tag_wdata;
	logic               x_link_we;
	logic               head_we;
	logic [CLASS_W-1:0] head_widx;
	head_t              head_wdata;
	logic               carve_we;

	logic [CARVE_W-1:0] carve_step;
	logic [CARVE_W:0]   carve_sum;
	logic [GRAN_W-1:0]  free_g;
	logic               free_aligned;
	logic               tag_ok;
	logic [CLASS_W-1:0] free_k;
	head_t              free_head;

	assign pick_in = pick_class({1'b0, in_size} + NEED_W'(HEADER_BYTES));
	assign accept  = in_valid && in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == GRAN_W'(NGRAN - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid && out_free) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC:  state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		clearing  = 1'b0;
		exec      = 1'b0;
		case (state_q)
			S_CLEAR: clearing = 1'b1;
			S_IDLE:  in_ready = out_free;
			S_EXEC: begin
				res_valid = 1'b1;
				exec      = 1'b1;
			end
			default: clearing = 1'b0;
		endcase
	end

	// read addresses are issued in the accept cycle
	assign tag_raddr  = in_faddr[ADDR_W-1:GRAN_SH];
	assign link_raddr = heads_q[pick_in[CLASS_W-1:0]].idx;

	assign carve_step   = CARVE_W'(1) << cls_q;
	assign carve_sum    = {1'b0, carve_q} + {1'b0, carve_step};
	assign free_g       = faddr_q[ADDR_W-1:GRAN_SH];
	assign free_aligned = faddr_q[GRAN_SH-1:0] == GRAN_SH'(HEADER_BYTES);
	assign tag_ok       = tag_rdata != '0 && tag_rdata <= TAG_W'(NUM_CLASSES);
	assign free_k       = tag_rdata - TAG_W'(1);
	assign free_head    = tag_ok ? heads_q[free_k] : '0;

	// resolve the request with the memory read data
	always_comb begin
		res         = '{size_class: '0, status: STAT_OK, addr: '0};
		x_tag_we    = 1'b0;
		x_tag_waddr = free_g;
		x_tag_wdata = '0;
		x_link_we   = 1'b0;
		link_waddr  = free_g;
		link_wdata  = free_head.valid ? free_head.idx : free_g;
		head_we     = 1'b0;
		head_widx   = cls_q;
		head_wdata  = '0;
		carve_we    = 1'b0;
		if (type_q == REQ_ALLOC) begin
			if (!cls_ok_q) begin
				res.status = STAT_TOO_LARGE;
			end else if (head_q.valid) begin
				// pop: a block that links to itself ends its list
				head_we          = 1'b1;
				head_wdata.valid = link_rdata != head_q.idx;
				head_wdata.idx   = link_rdata;
				x_tag_we         = 1'b1;
				x_tag_waddr      = head_q.idx;
				x_tag_wdata      = cls_q + TAG_W'(1);
				res.addr         = {head_q.idx, GRAN_SH'(HEADER_BYTES)};
				res.size_class   = cls_q;
			end else if (carve_sum > (CARVE_W + 1)'(NGRAN)) begin
				res.status     = STAT_OOM;
				res.size_class = cls_q;
			end else begin
				carve_we       = 1'b1;
				x_tag_we       = 1'b1;
				x_tag_waddr    = carve_q[GRAN_W-1:0];
				x_tag_wdata    = cls_q + TAG_W'(1);
				res.addr       = {carve_q[GRAN_W-1:0], GRAN_SH'(HEADER_BYTES)};
				res.size_class = cls_q;
			end
		end else begin
			if (faddr_q == '0) begin
				res.status = STAT_NULL_FREE;
			end else if (!free_aligned || !tag_ok) begin
				res.status = STAT_BAD_FREE;
			end else begin
				// push onto the class list, untag the block
				x_link_we        = 1'b1;
				head_we          = 1'b1;
				head_widx        = free_k;
				head_wdata.valid = 1'b1;
				head_wdata.idx   = free_g;
				x_tag_we         = 1'b1;
				res.size_class   = free_k;
			end
		end
	end

	assign tag_we    = clearing || (exec && x_tag_we);
	assign tag_waddr = clearing ? clr_q : x_tag_waddr;
	assign tag_wdata = clearing ? '0 : x_tag_wdata;

	// link writes only in the resolve cycle; the captured request is stale otherwise
	assign link_we   = exec && x_link_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			carve_q <= '0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				heads_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + GRAN_W'(1);
			end
			if (exec && head_we) begin
				heads_q[head_widx] <= head_wdata;
			end
			if (exec && carve_we) begin
				carve_q <= carve_sum[CARVE_W-1:0];
			end
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			type_q   <= in_type;
			cls_ok_q <= pick_in[CLASS_W];
			cls_q    <= pick_in[CLASS_W-1:0];
			head_q   <= heads_q[pick_in[CLASS_W-1:0]];
			faddr_q  <= in_faddr;
		end
	end

	a_res_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $past(accept))
		else $error("result without a preceding accepted request");

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !in_ready)
		else $error("request taken during tag clear");

	a_carve_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		carve_q <= CARVE_W'(NGRAN))
		else $error("carve pointer past end of pool");

	a_alloc_tags_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && x_tag_we && type_q == REQ_ALLOC) |-> (tag_wdata != '0))
		else $error("allocation writes an unallocated tag");

endmodule

FILE: hdl/size_class_block_allocator.sv
// ----------------------------------------------------------------------------
// size_class_block_allocator - segregated free list allocator, 9 classes
// Power-of-two block classes from 16 to 4096 bytes over a 32 KiB pool.
// ----------------------------------------------------------------------------
// In the accept cycle the block's class tag and the list head's link are read
// from synchronous memories; in the next cycle the request is resolved, the
// memories and list heads are written back and the result lands in the output
// register. A new request is taken only after the previous one is resolved and
// while the output register is free or draining. After reset the 2048-entry
// tag memory is swept to zero, one entry per cycle, and the input stays not
// ready until the sweep ends. An allocation adds the 8-byte header, rounds up to a
// class, pops that class's free list or carves at the bump pointer, and
// returns block start plus 8; a free pushes the block back onto its list.
// Status codes: 0 ok, 1 too large, 2 out of memory, 3 null free ignored,
// 4 bad free (misaligned, never allocated or already freed).
module size_class_block_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [11:0] req_size, [26:12] free_addr, rest 0
	input  logic [0:0]  s_axis_tuser,  // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // [14:0] addr, [17:15] status, [21:18] size_class
);
	import scba_pkg::*;

	logic               out_free;
	logic               res_valid;
	result_t            res;
	result_t            res_q;
	logic               m_tvalid_q;

	logic               tag_we;
	logic [GRAN_W-1:0]  tag_waddr;
	logic [TAG_W-1:0]   tag_wdata;
	logic [GRAN_W-1:0]  tag_raddr;
	logic [TAG_W-1:0]   tag_rdata;
	logic               link_we;
	logic [GRAN_W-1:0]  link_waddr;
	logic [GRAN_W-1:0]  link_wdata;
	logic [GRAN_W-1:0]  link_raddr;
	logic [GRAN_W-1:0]  link_rdata;

	// a request is only taken when its result will find the output slot free
	assign out_free = !m_tvalid_q || m_axis_tready;

	scba_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_type    (req_type_t'(s_axis_tuser[0])),
		.in_size    (s_axis_tdata[SIZE_W-1:0]),
		.in_faddr   (s_axis_tdata[SIZE_W+ADDR_W-1:SIZE_W]),
		.out_free   (out_free),
		.res_valid  (res_valid),
		.res        (res),
		.tag_we     (tag_we),
		.tag_waddr  (tag_waddr),
		.tag_wdata  (tag_wdata),
		.tag_raddr  (tag_raddr),
		.tag_rdata  (tag_rdata),
		.link_we    (link_we),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.link_raddr (link_raddr),
		.link_rdata (link_rdata)
	);

	// class tag per granule: 0 free, class + 1 when allocated
	scba_ram #(
		.DEPTH (NGRAN),
		.WIDTH (TAG_W)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (tag_wdata),
		.raddr (tag_raddr),
		.rdata (tag_rdata)
	);

	// free list links; only links of entries on a list are used
	scba_ram #(
		.DEPTH (NGRAN),
		.WIDTH (GRAN_W)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	// output register: load a fresh result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// hold the payload while the transaction waits
	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {(OUT_DATA_W - OUT_RES_W)'(0), res_q};

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !m_tvalid_q)
		else $error("result overwrites a pending output transaction");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the size class block allocator
// Streams allocate and free requests into the slave port, predicts every
// result with a behavioral allocator kept inside the bench, and checks each
// result transaction on the master port field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
	import scba_pkg::*;

	localparam int RANDOM_ITEMS  = 1825;      // after the directed opening
	localparam int CHUNK         = 8;         // requests queued per refill
	localparam int QUIET_TAIL    = 300;       // last requests run without idling
	localparam int IDLE_SEGMENT  = 96;        // requests between idle-rate changes
	localparam int DRAIN_EVERY   = 600;       // requests between full drains
	localparam int RECENT_DEPTH  = 32;        // freed addresses kept for double frees
	localparam int MAX_REPORTS   = 50;
	localparam int SETTLE_CYCLES = 8;
	localparam int LIMIT_NS      = 2_000_000; // well above the time of a slow run

	typedef struct packed {
		req_type_t         kind;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] faddr;
	} request_t;

	// ------------------------------------------------------------------------
	// DUT hookup; every input starts at a known value
	// ------------------------------------------------------------------------
	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;  // [11:0] req_size, [26:12] free_addr, rest 0
	logic [0:0]  s_axis_tuser  = '0;  // [0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // [14:0] addr, [17:15] status, [21:18] size_class

	size_class_block_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Hold reset at start, release it at a falling edge, away from the rising edge.
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ------------------------------------------------------------------------
	// Allocator state as the bench sees it
	// ------------------------------------------------------------------------
	head_t              list_head [NUM_CLASSES];  // free list head per class
	logic [CARVE_W-1:0] bump_gran;                // next uncarved granule
	logic [GRAN_W-1:0]  next_gran [NGRAN];        // list link; list end links to itself
	logic [TAG_W-1:0]   owner_tag [NGRAN];        // 0 free, class+1 while allocated

	request_t          request_q[$];        // requests waiting for the driver
	result_t           pending_results[$];  // predictions not yet seen on the output
	logic [ADDR_W-1:0] live_blocks[$];      // allocated and not yet scheduled for free
	logic [ADDR_W-1:0] recent_frees[$];     // targets of recent frees
	request_t          in_flight;

	int send_gap;
	int stall_left;
	int sender_idle_pct;
	int sink_stall_pct;
	int errors;
	int checked;
	int n_alloc;
	int n_free;
	int status_seen [8];

	function automatic void drop_live(input logic [ADDR_W-1:0] a);
		for (int i = 0; i < live_blocks.size(); i++) begin
			if (live_blocks[i] == a) begin
				live_blocks.delete(i);
				return;
			end
		end
	endfunction

	// Apply one accepted request to the bench allocator and return its result.
	function automatic result_t serve_request(input request_t r);
		result_t res;
		int      need;
		int      k;
		int      g;
		res.addr       = '0;
		res.status     = STAT_OK;
		res.size_class = '0;
		g              = 0;
		if (r.kind == REQ_ALLOC) begin
			// round header plus payload up to the smallest class that holds it
			need = int'(r.size) + HEADER_BYTES;
			k    = 0;
			while (k < NUM_CLASSES && (GRAN_BYTES << k) < need)
				k++;
			if (k == NUM_CLASSES || (GRAN_BYTES << k) > MAX_BLOCK_BYTES) begin
				res.status = STAT_TOO_LARGE;
			end else begin
				res.size_class = CLASS_W'(k);
				if (list_head[k].valid) begin
					// pop; a self link marks the last block on the list
					g = int'(list_head[k].idx);
					if (int'(next_gran[g]) == g)
						list_head[k] = '0;
					else
						list_head[k] = '{valid: 1'b1, idx: next_gran[g]};
				end else if (int'(bump_gran) + (1 << k) > NGRAN) begin
					res.status = STAT_OOM;
				end else begin
					g         = int'(bump_gran);
					bump_gran = bump_gran + CARVE_W'(1 << k);
				end
				if (res.status == STAT_OK) begin
					owner_tag[g] = TAG_W'(k + 1);
					res.addr     = ADDR_W'(g * GRAN_BYTES + HEADER_BYTES);
					live_blocks.push_back(res.addr);
				end
			end
		end else if (r.faddr == '0) begin
			res.status = STAT_NULL_FREE;
		end else begin
			g = (int'(r.faddr) - HEADER_BYTES) / GRAN_BYTES;
			if (int'(r.faddr) < HEADER_BYTES ||
			    (int'(r.faddr) - HEADER_BYTES) % GRAN_BYTES != 0 ||
			    owner_tag[g] == '0 || int'(owner_tag[g]) > NUM_CLASSES) begin
				// misaligned, never allocated or already freed
				res.status = STAT_BAD_FREE;
			end else begin
				k            = int'(owner_tag[g]) - 1;
				next_gran[g] = list_head[k].valid ? list_head[k].idx : GRAN_W'(g);
				list_head[k] = '{valid: 1'b1, idx: GRAN_W'(g)};
				owner_tag[g] = '0;
				res.size_class = CLASS_W'(k);
				drop_live(r.faddr);
			end
		end
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Request builders
	// ------------------------------------------------------------------------
	function automatic void queue_alloc(input int size);
		request_q.push_back('{kind: REQ_ALLOC, size: SIZE_W'(size), faddr: ADDR_W'($urandom)});
	endfunction

	// Take the target off the live list so no later request frees it twice by accident.
	function automatic void queue_free(input logic [ADDR_W-1:0] a);
		drop_live(a);
		recent_frees.push_back(a);
		if (recent_frees.size() > RECENT_DEPTH)
			void'(recent_frees.pop_front());
		request_q.push_back('{kind: REQ_FREE, size: SIZE_W'($urandom), faddr: a});
	endfunction

	function automatic void queue_random_request();
		int roll;
		int free_pct;
		int k;
		int lo;
		int hi;
		roll     = $urandom_range(99);
		free_pct = (live_blocks.size() > 200) ? 60 : (live_blocks.size() > 20) ? 45 : 25;
		if (roll < 6) begin
			// noise: null, stray address, double free, or an address inside a live block
			case ($urandom_range(3))
				0: queue_free('0);
				1: queue_free(ADDR_W'($urandom));
				2: begin
					if (recent_frees.size() != 0)
						queue_free(recent_frees[$urandom_range(recent_frees.size() - 1)]);
					else
						queue_free('0);
				end
				default: begin
					if (live_blocks.size() != 0)
						queue_free(live_blocks[$urandom_range(live_blocks.size() - 1)] +
						           ADDR_W'($urandom_range(GRAN_BYTES - 1, 1)));
					else
						queue_free(ADDR_W'($urandom_range(HEADER_BYTES - 1, 1)));
				end
			endcase
		end else if (roll < 6 + free_pct && live_blocks.size() != 0) begin
			queue_free(live_blocks[$urandom_range(live_blocks.size() - 1)]);
		end else if (roll >= 97) begin
			// payload plus header beyond the largest class
			queue_alloc($urandom_range(MAX_BLOCK_BYTES - 1, MAX_BLOCK_BYTES - HEADER_BYTES + 1));
		end else begin
			// lean toward small classes so the bump area lasts a while
			hi = $urandom_range(99);
			if (hi < 45)
				k = $urandom_range(3);
			else if (hi < 85)
				k = $urandom_range(6, 4);
			else
				k = $urandom_range(NUM_CLASSES - 1, NUM_CLASSES - 2);
			lo = (k == 0) ? HEADER_BYTES : (GRAN_BYTES << (k - 1)) + 1;
			hi = GRAN_BYTES << k;
			queue_alloc(int'($urandom_range(hi, lo)) - HEADER_BYTES);
		end
	endfunction

	// Sample at the falling edge so every update of the rising edge has landed.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (request_q.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
	endtask

	// ------------------------------------------------------------------------
	// Driver: present queued requests, predict on each accepted transaction
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			send_gap = 0;
			bump_gran = '0;
			for (int k = 0; k < NUM_CLASSES; k++)
				list_head[k] = '0;
			for (int g = 0; g < NGRAN; g++)
				owner_tag[g] = '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				result_t res;
				res = serve_request(in_flight);
				pending_results.push_back(res);
				status_seen[res.status]++;
				if (in_flight.kind == REQ_ALLOC)
					n_alloc++;
				else
					n_free++;
				if ($urandom_range(99) < sender_idle_pct)
					send_gap = $urandom_range(5, 1);
			end
			// hold a transaction that is still waiting for ready
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (request_q.size() != 0) begin
					in_flight = request_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {5'b0, in_flight.faddr, in_flight.size};
					s_axis_tuser  <= in_flight.kind;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: stall the output at random, check every result transaction
	// ------------------------------------------------------------------------
	function automatic void compare_field(input string what, input int want, input int got);
		if (want != got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	function automatic void check_result(input result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t ns: result with nothing expected, expected none, got addr %0d status %0d class %0d",
				         $time, got.addr, got.status, got.size_class);
			return;
		end
		want = pending_results.pop_front();
		checked++;
		compare_field("addr", int'(want.addr), int'(got.addr));
		compare_field("status", int'(want.status), int'(got.status));
		compare_field("size_class", int'(want.size_class), int'(got.size_class));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result(result_t'(m_axis_tdata[OUT_RES_W-1:0]));
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(99) < sink_stall_pct) begin
				stall_left = $urandom_range(4);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int n;
		sender_idle_pct = 25;
		sink_stall_pct  = 25;

		// Directed opening. From reset the first blocks carve from granule 0,
		// so their addresses are known in advance.
		queue_alloc(0);                                  // smallest class, granule 0
		queue_alloc(GRAN_BYTES - HEADER_BYTES);          // exact fit of the smallest class
		queue_alloc(GRAN_BYTES - HEADER_BYTES + 1);      // one byte over: next class
		queue_alloc(MAX_BLOCK_BYTES - HEADER_BYTES);     // largest class, granule 4
		queue_alloc(MAX_BLOCK_BYTES - HEADER_BYTES + 1); // too large by one byte
		queue_alloc((1 << SIZE_W) - 1);                  // largest size field
		queue_free('0);                                  // null free
		queue_free(ADDR_W'(HEADER_BYTES - 3));           // below the header
		queue_free(ADDR_W'(HEADER_BYTES + 4));           // misaligned
		queue_free(ADDR_W'(POOL_BYTES - HEADER_BYTES));  // last granule, never allocated
		queue_free(ADDR_W'(HEADER_BYTES));               // first block back on its list
		queue_free(ADDR_W'(HEADER_BYTES));               // double free
		queue_free(ADDR_W'(GRAN_BYTES + HEADER_BYTES));  // second block links to the first
		queue_alloc(1);                                  // pop the head
		queue_alloc(2);                                  // pop the self-linked tail
		queue_alloc(3);                                  // list empty: carve again
		queue_free(ADDR_W'(5 * GRAN_BYTES + HEADER_BYTES)); // inside the large block
		repeat (7)
			queue_alloc(MAX_BLOCK_BYTES - HEADER_BYTES); // last one runs out of pool
		queue_free(ADDR_W'((1 << ADDR_W) - 1));          // all address bits set

		// Random part: refill in small chunks so frees can target live blocks.
		n = 0;
		while (n < RANDOM_ITEMS) begin
			@(posedge clk);
			if (request_q.size() <= 2) begin
				if (n != 0 && n % DRAIN_EVERY == 0)
					wait_drained();  // let the output catch up before going on
				if (n >= RANDOM_ITEMS - QUIET_TAIL) begin
					sender_idle_pct = 0;
					sink_stall_pct  = 0;
				end else if (n % IDLE_SEGMENT == 0) begin
					sender_idle_pct = 25 * $urandom_range(2);
					sink_stall_pct  = 25 * $urandom_range(2);
				end
				repeat (CHUNK) begin
					queue_random_request();
					n++;
				end
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("tb_top: %0d requests (%0d allocate, %0d free), %0d results checked",
		         n_alloc + n_free, n_alloc, n_free, checked);
		$display("tb_top: ok %0d, too large %0d, out of memory %0d, null free %0d, bad free %0d",
		         status_seen[STAT_OK], status_seen[STAT_TOO_LARGE], status_seen[STAT_OOM],
		         status_seen[STAT_NULL_FREE], status_seen[STAT_BAD_FREE]);
		if (errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	// Bail out if the handshakes never complete.
	initial begin
		#(LIMIT_NS);
		$display("tb_top: timed out with %0d results outstanding", pending_results.size());
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
hdl/scba_pkg.sv
hdl/scba_ram.sv
hdl/scba_ctrl.sv
hdl/size_class_block_allocator.sv
tb/tb_top.sv
